FILE: src/assert_macros.svh
// Assertion macros used by the steering force top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define SFPE_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("steering check failed");
// Check a property on every clock edge, reset included
`define SFPE_CHECK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("steering check failed");
`else
`define SFPE_CHECK(lbl, clk, rst_n, prop)
`define SFPE_CHECK_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/sfpe_pkg.sv
`timescale 1ns / 1ps
// Widths, latencies and codes shared by the steering force pipeline
package sfpe_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int UNS_W      = WORD_W - 1;
    localparam int DIFF_W     = WORD_W + 1;
    localparam int LEN_W      = WORD_W + 2;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int QUO_W      = WORD_W;
    localparam int SQRT_STEPS = WORD_W;
    localparam int NORM_LAT   = SQRT_STEPS + 4;
    localparam int DIV_LAT    = QUO_W + 1;
    localparam int PIPE_LAT   = 2 * NORM_LAT + 2 * DIV_LAT + 10;

    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    localparam logic [UNS_W-1:0] DZ_RESET = UNS_W'(6554);

    localparam logic [CMD_W-1:0] CMD_SEEK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLEE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURSUIT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EVADE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_ZTS  = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [UNS_W-1:0]         t_uns;
    typedef logic signed [DIFF_W-1:0] t_diff;

endpackage

FILE: src/sfpe_norm.sv
`timescale 1ns / 1ps
// Pipelined vector length: common pre-shift, squares, one square-root step per stage
module sfpe_norm (
    input  logic                          i_clk,
    input  logic signed [sfpe_pkg::DIFF_W-1:0] i_x,
    input  logic signed [sfpe_pkg::DIFF_W-1:0] i_y,
    output logic [sfpe_pkg::LEN_W-1:0]    o_len
);
    import sfpe_pkg::*;

    localparam int MAG_W = DIFF_W;
    localparam int RED_W = WORD_W - 1;
    localparam int SQ_W  = 2 * RED_W;
    localparam int ACC_W = PROD_W;
    localparam int SH_W  = 2;

    logic [MAG_W-1:0] ax, ay, ao;
    logic [SH_W-1:0]  sh;

    logic [RED_W-1:0] r_ax, r_ay;
    logic [SH_W-1:0]  r_sh1, r_sh2;
    logic [SQ_W-1:0]  r_xx, r_yy;
    logic [ACC_W-1:0] r_v  [0:SQRT_STEPS];
    logic [ACC_W-1:0] r_r  [0:SQRT_STEPS];
    logic [SH_W-1:0]  r_sh [0:SQRT_STEPS];
    logic [LEN_W-1:0] r_len;

    always_comb begin
        ax = i_x[DIFF_W-1] ? $unsigned(-i_x) : $unsigned(i_x);
        ay = i_y[DIFF_W-1] ? $unsigned(-i_y) : $unsigned(i_y);
        ao = ax | ay;
        // smallest shift that brings both magnitudes below 2^31
        priority if (ao[MAG_W-1]) begin
            sh = 2'd2;
        end else if (ao[MAG_W-2]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= RED_W'(ax >> sh);
        r_ay   <= RED_W'(ay >> sh);
        r_sh1  <= sh;
        r_xx   <= {{RED_W{1'b0}}, r_ax} * {{RED_W{1'b0}}, r_ax};
        r_yy   <= {{RED_W{1'b0}}, r_ay} * {{RED_W{1'b0}}, r_ay};
        r_sh2  <= r_sh1;
        r_v[0] <= {2'b00, r_xx} + {2'b00, r_yy};
        r_r[0] <= '0;
        r_sh[0] <= r_sh2;
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
        localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (ACC_W - 2 * k);
        logic [ACC_W-1:0] trial;
        logic             ge;

        always_comb begin
            trial = r_r[k-1] + BIT;
            ge    = r_v[k-1] >= trial;
        end

        always_ff @(posedge i_clk) begin
            r_v[k]  <= ge ? r_v[k-1] - trial : r_v[k-1];
            r_r[k]  <= ge ? (r_r[k-1] >> 1) + BIT : r_r[k-1] >> 1;
            r_sh[k] <= r_sh[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= LEN_W'(r_r[SQRT_STEPS][QUO_W-1:0]) << r_sh[SQRT_STEPS];
    end

    assign o_len = r_len;

endmodule

FILE: src/sfpe_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: overflow check, then one quotient bit per stage
module sfpe_div (
    input  logic                          i_clk,
    input  logic [sfpe_pkg::PROD_W-1:0]   i_num,
    input  logic [sfpe_pkg::LEN_W-1:0]    i_den,
    output logic [sfpe_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_ovf
);
    import sfpe_pkg::*;

    localparam int EXT_W = LEN_W + QUO_W;

    logic [PROD_W-1:0] r_rem [0:QUO_W];
    logic [LEN_W-1:0]  r_den [0:QUO_W];
    logic [QUO_W-1:0]  r_q   [0:QUO_W];
    logic              r_ovf [0:QUO_W];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        // quotient would not fit in QUO_W bits
        r_ovf[0] <= EXT_W'(i_num) >= {i_den, {QUO_W{1'b0}}};
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - k;
        logic [EXT_W-1:0] shifted;
        logic             ge;
        logic [QUO_W-1:0] n_q;

        always_comb begin
            shifted = EXT_W'(r_den[k-1]) << SH;
            ge      = EXT_W'(r_rem[k-1]) >= shifted;
            n_q     = r_q[k-1];
            n_q[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? r_rem[k-1] - shifted[PROD_W-1:0] : r_rem[k-1];
            r_den[k] <= r_den[k-1];
            r_q[k]   <= n_q;
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_quo = r_q[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

FILE: src/seek_flee_pursuit_evade_steering_top.sv
`timescale 1ns / 1ps
// Steering force pipeline: seek, flee, pursuit and evade in signed Q16.16
// Usage:
//   Request channel: drive the fields and raise start; a beat is taken at every
//   rising edge with start high and busy low. busy stays low, so one request
//   per cycle is taken with no gaps.
//   Result channel: o_done marks each result for exactly one cycle, with
//   o_force_x, o_force_y and o_status valid in that cycle. Results leave in
//   request order. The receiver cannot stall; no result is held back.
//   Pipeline: a request passes two length units (36 stages each), two
//   33-stage divider pipelines and ten single stages before o_done marks
//   its result.
//   Throughput: one request per cycle.
//   Config channel: i_cfg_valid/o_cfg_ready write the dead zone radius;
//   o_cfg_ready is always high. Write it only while no request is in flight.
//   Reset: synchronous, active low; drops every beat in flight and sets the
//   dead zone radius back to 0.1 (6554).
//   Status: 0 ok, 1 dead zone, 2 zero target speed, 3 saturated.
`include "assert_macros.svh"
module seek_flee_pursuit_evade_steering_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sfpe_pkg::CMD_W-1:0]    i_cmd,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_self_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_self_y,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_self_vel_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_self_vel_y,
    input  logic [sfpe_pkg::UNS_W-1:0]    i_speed,
    input  logic [sfpe_pkg::UNS_W-1:0]    i_mass,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_target_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_target_y,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_target_vel_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0] i_target_vel_y,
    input  logic [sfpe_pkg::UNS_W-1:0]    i_target_max_speed,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfpe_pkg::UNS_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic signed [sfpe_pkg::WORD_W-1:0] o_force_x,
    output logic signed [sfpe_pkg::WORD_W-1:0] o_force_y,
    output logic [sfpe_pkg::ST_W-1:0]     o_status
);
    import sfpe_pkg::*;

    localparam int PX_W = WORD_W + UNS_W;
    localparam logic [PROD_W-1:0] LIM_POS = (PROD_W'(1) << (WORD_W - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(1) << (WORD_W - 1);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_word            sx, sy, svx, svy;
        t_uns             speed, mass;
        t_word            tx, ty, tvx, tvy;
        t_uns             tms;
    } t_req;

    typedef struct packed {
        logic  zts;
        logic  sat;
        t_diff dx, dy;
        t_word svx, svy;
        t_uns  speed, mass;
    } t_dir;

    typedef struct packed {
        logic  zts;
        logic  sat;
        logic  dead;
        logic  xneg, yneg;
        t_word svx, svy;
        t_uns  mass;
    } t_tail;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_clamp;

    // sign and magnitude back to a word, clamped to the signed range
    function automatic t_clamp from_mag(input logic neg, input logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] lim;
        logic [WORD_W-1:0] mm;
        t_clamp            res;
        lim     = neg ? LIM_NEG : LIM_POS;
        res.sat = m > lim;
        mm      = res.sat ? lim[WORD_W-1:0] : m[WORD_W-1:0];
        res.val = neg ? -mm : mm;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] mag_word(input t_word v);
        return v[WORD_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [DIFF_W-1:0] mag_diff(input t_diff v);
        return v[DIFF_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic t_clamp sat_sum(input t_diff s);
        t_clamp res;
        res.sat = s[DIFF_W-1] != s[DIFF_W-2];
        res.val = res.sat ? (s[DIFF_W-1] ? t_word'(LIM_NEG[WORD_W-1:0])
                                         : t_word'(LIM_POS[WORD_W-1:0]))
                          : s[WORD_W-1:0];
        return res;
    endfunction

    // configuration
    logic [UNS_W-1:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dz <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // input stage
    logic r_a_vld;
    t_req r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a <= '{cmd: i_cmd, sx: i_self_x, sy: i_self_y, svx: i_self_vel_x,
                 svy: i_self_vel_y, speed: i_speed, mass: i_mass, tx: i_target_x,
                 ty: i_target_y, tvx: i_target_vel_x, tvy: i_target_vel_y,
                 tms: i_target_max_speed};
    end

    // distance to the other agent
    t_diff            d1x, d1y;
    logic [LEN_W-1:0] len1;

    assign d1x = DIFF_W'(r_a.tx) - DIFF_W'(r_a.sx);
    assign d1y = DIFF_W'(r_a.ty) - DIFF_W'(r_a.sy);

    sfpe_norm u_norm_ahead (
        .i_clk (i_clk),
        .i_x   (d1x),
        .i_y   (d1y),
        .o_len (len1)
    );

    logic [NORM_LAT-1:0] r_d1_vld;
    t_req                r_d1 [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= '0;
        end else begin
            r_d1_vld <= {r_d1_vld[NORM_LAT-2:0], r_a_vld};
        end
        r_d1[0] <= r_a;
        for (int k = 1; k < NORM_LAT; k++) begin
            r_d1[k] <= r_d1[k-1];
        end
    end

    // look-ahead time: distance / target max speed
    t_req             d1_out;
    logic [QUO_W-1:0] quo_a;
    logic             ovf_a;

    assign d1_out = r_d1[NORM_LAT-1];

    sfpe_div u_div_ahead (
        .i_clk (i_clk),
        .i_num ({{(PROD_W - LEN_W - FRAC_W){1'b0}}, len1, {FRAC_W{1'b0}}}),
        .i_den (LEN_W'(d1_out.tms)),
        .o_quo (quo_a),
        .o_ovf (ovf_a)
    );

    logic [DIV_LAT-1:0] r_d2_vld;
    t_req               r_d2 [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_vld <= '0;
        end else begin
            r_d2_vld <= {r_d2_vld[DIV_LAT-2:0], r_d1_vld[NORM_LAT-1]};
        end
        r_d2[0] <= d1_out;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_d2[k] <= r_d2[k-1];
        end
    end

    // prediction of the other agent's position
    logic              r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    t_req              r_p1, r_p2, r_p3, r_p4;
    t_uns              r_p1_ahead;
    logic              r_p1_sat, r_p2_sat, r_p3_sat, r_p4_sat, r_p4_zts;
    logic [PX_W-1:0]   r_p2_px, r_p2_py;
    t_word             r_p3_mx, r_p3_my, r_p4_tx, r_p4_ty;
    logic              ahead_ovf, is_pred;
    t_clamp            cl_mx, cl_my, cl_tx, cl_ty;

    assign ahead_ovf = ovf_a || quo_a[QUO_W-1];
    assign cl_mx     = from_mag(r_p2.tvx[WORD_W-1], PROD_W'(r_p2_px >> FRAC_W));
    assign cl_my     = from_mag(r_p2.tvy[WORD_W-1], PROD_W'(r_p2_py >> FRAC_W));
    assign cl_tx     = sat_sum(DIFF_W'(r_p3.tx) + DIFF_W'(r_p3_mx));
    assign cl_ty     = sat_sum(DIFF_W'(r_p3.ty) + DIFF_W'(r_p3_my));
    assign is_pred   = r_p3.cmd == CMD_PURSUIT || r_p3.cmd == CMD_EVADE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else begin
            r_p1_vld <= r_d2_vld[DIV_LAT-1];
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
        end
        r_p1       <= r_d2[DIV_LAT-1];
        r_p1_ahead <= ahead_ovf ? '1 : quo_a[UNS_W-1:0];
        r_p1_sat   <= ahead_ovf;

        r_p2       <= r_p1;
        r_p2_sat   <= r_p1_sat;
        r_p2_px    <= {{UNS_W{1'b0}}, mag_word(r_p1.tvx)} * {{WORD_W{1'b0}}, r_p1_ahead};
        r_p2_py    <= {{UNS_W{1'b0}}, mag_word(r_p1.tvy)} * {{WORD_W{1'b0}}, r_p1_ahead};

        r_p3       <= r_p2;
        r_p3_mx    <= cl_mx.val;
        r_p3_my    <= cl_my.val;
        r_p3_sat   <= r_p2_sat || cl_mx.sat || cl_my.sat;

        // seek and flee keep the target point as given
        r_p4       <= r_p3;
        r_p4_tx    <= is_pred ? cl_tx.val : r_p3.tx;
        r_p4_ty    <= is_pred ? cl_ty.val : r_p3.ty;
        r_p4_sat   <= is_pred && (r_p3_sat || cl_tx.sat || cl_ty.sat);
        r_p4_zts   <= is_pred && (r_p3.tms == '0);
    end

    // desired direction
    t_dir             n_dir;
    logic             away;
    logic [LEN_W-1:0] len2;

    always_comb begin
        away        = r_p4.cmd == CMD_FLEE || r_p4.cmd == CMD_EVADE;
        n_dir.zts   = r_p4_zts;
        n_dir.sat   = r_p4_sat;
        n_dir.dx    = away ? DIFF_W'(r_p4.sx) - DIFF_W'(r_p4_tx)
                           : DIFF_W'(r_p4_tx) - DIFF_W'(r_p4.sx);
        n_dir.dy    = away ? DIFF_W'(r_p4.sy) - DIFF_W'(r_p4_ty)
                           : DIFF_W'(r_p4_ty) - DIFF_W'(r_p4.sy);
        n_dir.svx   = r_p4.svx;
        n_dir.svy   = r_p4.svy;
        n_dir.speed = r_p4.speed;
        n_dir.mass  = r_p4.mass;
    end

    sfpe_norm u_norm_dir (
        .i_clk (i_clk),
        .i_x   (n_dir.dx),
        .i_y   (n_dir.dy),
        .o_len (len2)
    );

    logic [NORM_LAT-1:0] r_d3_vld;
    t_dir                r_d3 [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3_vld <= '0;
        end else begin
            r_d3_vld <= {r_d3_vld[NORM_LAT-2:0], r_p4_vld};
        end
        r_d3[0] <= n_dir;
        for (int k = 1; k < NORM_LAT; k++) begin
            r_d3[k] <= r_d3[k-1];
        end
    end

    // scale to the requested speed: |d| * speed / length
    t_dir              d3_out;
    logic              r_m1_vld;
    t_tail             r_m1;
    logic [PROD_W-1:0] r_m1_nx, r_m1_ny;
    logic [LEN_W-1:0]  r_m1_len;

    assign d3_out = r_d3[NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= r_d3_vld[NORM_LAT-1];
        end
        r_m1.zts  <= d3_out.zts;
        r_m1.sat  <= d3_out.sat;
        r_m1.dead <= len2 <= LEN_W'(r_dz);
        r_m1.xneg <= d3_out.dx[DIFF_W-1];
        r_m1.yneg <= d3_out.dy[DIFF_W-1];
        r_m1.svx  <= d3_out.svx;
        r_m1.svy  <= d3_out.svy;
        r_m1.mass <= d3_out.mass;
        r_m1_nx   <= {{UNS_W{1'b0}}, mag_diff(d3_out.dx)} * {{DIFF_W{1'b0}}, d3_out.speed};
        r_m1_ny   <= {{UNS_W{1'b0}}, mag_diff(d3_out.dy)} * {{DIFF_W{1'b0}}, d3_out.speed};
        r_m1_len  <= len2;
    end

    logic [QUO_W-1:0] quo_x, quo_y;
    logic             ovf_x, ovf_y;

    sfpe_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_m1_nx),
        .i_den (r_m1_len),
        .o_quo (quo_x),
        .o_ovf (ovf_x)
    );

    sfpe_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_m1_ny),
        .i_den (r_m1_len),
        .o_quo (quo_y),
        .o_ovf (ovf_y)
    );

    logic [DIV_LAT-1:0] r_d4_vld;
    t_tail              r_d4 [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d4_vld <= '0;
        end else begin
            r_d4_vld <= {r_d4_vld[DIV_LAT-2:0], r_m1_vld};
        end
        r_d4[0] <= r_m1;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_d4[k] <= r_d4[k-1];
        end
    end

    // force = (desired - velocity) * mass
    t_tail             d4_out;
    t_tail             n_f1;
    t_clamp            cl_dx, cl_dy, cl_fx, cl_fy;
    logic              r_f1_vld, r_f2_vld, r_f3_vld;
    t_tail             r_f1, r_f2, r_f3;
    t_word             r_f1_dx, r_f1_dy;
    t_diff             r_f2_ex, r_f2_ey;
    logic [PROD_W-1:0] r_f3_px, r_f3_py;
    logic              r_f3_nx, r_f3_ny;
    logic              r_done;
    t_word             r_force_x, r_force_y;
    logic [ST_W-1:0]   r_status;

    assign d4_out = r_d4[DIV_LAT-1];
    assign cl_dx  = from_mag(d4_out.xneg, ovf_x ? '1 : PROD_W'(quo_x));
    assign cl_dy  = from_mag(d4_out.yneg, ovf_y ? '1 : PROD_W'(quo_y));
    assign cl_fx  = from_mag(r_f3_nx, r_f3_px >> FRAC_W);
    assign cl_fy  = from_mag(r_f3_ny, r_f3_py >> FRAC_W);

    always_comb begin
        n_f1     = d4_out;
        n_f1.sat = d4_out.sat || cl_dx.sat || cl_dy.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_f1_vld <= r_d4_vld[DIV_LAT-1];
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_done   <= r_f3_vld;
        end
        r_f1     <= n_f1;
        r_f1_dx  <= cl_dx.val;
        r_f1_dy  <= cl_dy.val;

        r_f2     <= r_f1;
        r_f2_ex  <= DIFF_W'(r_f1_dx) - DIFF_W'(r_f1.svx);
        r_f2_ey  <= DIFF_W'(r_f1_dy) - DIFF_W'(r_f1.svy);

        r_f3     <= r_f2;
        r_f3_nx  <= r_f2_ex[DIFF_W-1];
        r_f3_ny  <= r_f2_ey[DIFF_W-1];
        r_f3_px  <= {{UNS_W{1'b0}}, mag_diff(r_f2_ex)} * {{DIFF_W{1'b0}}, r_f2.mass};
        r_f3_py  <= {{UNS_W{1'b0}}, mag_diff(r_f2_ey)} * {{DIFF_W{1'b0}}, r_f2.mass};

        // zero target speed outranks the dead zone, which outranks saturation
        priority if (r_f3.zts) begin
            r_force_x <= '0;
            r_force_y <= '0;
            r_status  <= ST_ZTS;
        end else if (r_f3.dead) begin
            r_force_x <= '0;
            r_force_y <= '0;
            r_status  <= ST_DEAD;
        end else begin
            r_force_x <= cl_fx.val;
            r_force_y <= cl_fy.val;
            r_status  <= (r_f3.sat || cl_fx.sat || cl_fy.sat) ? ST_SAT : ST_OK;
        end
    end

    assign o_done    = r_done;
    assign o_force_x = r_force_x;
    assign o_force_y = r_force_y;
    assign o_status  = r_status;

    `SFPE_CHECK(a_zero_force, i_clk, i_rst_n, o_done && (o_status == ST_ZTS || o_status == ST_DEAD) |-> o_force_x == '0 && o_force_y == '0)
    `SFPE_CHECK(a_latency, i_clk, i_rst_n, o_done |-> $past(start, PIPE_LAT))
    `SFPE_CHECK(a_zts_src, i_clk, i_rst_n, o_done && o_status == ST_ZTS |-> $past(i_target_max_speed, PIPE_LAT) == '0 && ($past(i_cmd, PIPE_LAT) == CMD_PURSUIT || $past(i_cmd, PIPE_LAT) == CMD_EVADE))
    `SFPE_CHECK_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_done)

endmodule

FILE: sim/steering_checker.sv
`timescale 1ns / 1ps
// Steering force checker: predicts every accepted request and compares results in order
module steering_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [sfpe_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_self_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_self_y,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_self_vel_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_self_vel_y,
    input  logic [sfpe_pkg::UNS_W-1:0]           i_speed,
    input  logic [sfpe_pkg::UNS_W-1:0]           i_mass,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_target_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_target_y,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_target_vel_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   i_target_vel_y,
    input  logic [sfpe_pkg::UNS_W-1:0]           i_target_max_speed,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [sfpe_pkg::UNS_W-1:0]           i_cfg_data,
    input  logic                                 o_done,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   o_force_x,
    input  logic signed [sfpe_pkg::WORD_W-1:0]   o_force_y,
    input  logic [sfpe_pkg::ST_W-1:0]            o_status,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import sfpe_pkg::*;

    localparam logic signed [63:0] W_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN = -64'sd2147483648;
    localparam logic [63:0]        ONE_Q = 64'd1 << FRAC_W;

    typedef struct packed {
        t_word           fx;
        t_word           fy;
        logic [ST_W-1:0] st;
    } t_force;

    t_force     force_q[$];
    t_uns       dead_zone;
    bit         clipped;
    int         mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = force_q.size();

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] r, b, rem;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        rem = v;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // shift both magnitudes together until they fit in 31 bits
    function automatic logic [63:0] vec_length(input logic signed [63:0] x,
                                               input logic signed [63:0] y);
        logic [63:0] ax, ay;
        int sh;
        ax = magnitude(x);
        ay = magnitude(y);
        sh = 0;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax = ax >> 1;
            ay = ay >> 1;
            sh++;
        end
        return sqrt_floor(ax * ax + ay * ay) << sh;
    endfunction

    // sign(a) * trunc(|a| * b / c), clamped to the word range
    function automatic logic signed [63:0] scale_clip(input logic signed [63:0] a,
                                                      input logic [63:0] b,
                                                      input logic [63:0] c);
        logic [127:0] prod, quo, lim;
        prod = 128'(magnitude(a)) * 128'(b);
        lim  = (a < 0) ? 128'd2147483648 : 128'd2147483647;
        if (c == 0) begin
            quo = lim + 1;
        end else begin
            quo = prod / 128'(c);
        end
        if (quo > lim) begin
            quo = lim;
            clipped = 1'b1;
        end
        return (a < 0) ? -$signed(64'(quo)) : $signed(64'(quo));
    endfunction

    function automatic logic signed [63:0] clip_word(input logic signed [63:0] v);
        if (v > W_MAX) begin
            clipped = 1'b1;
            return W_MAX;
        end
        if (v < W_MIN) begin
            clipped = 1'b1;
            return W_MIN;
        end
        return v;
    endfunction

    function automatic t_force predict_force();
        t_force f;
        logic signed [63:0] sx, sy, tx, ty, dx, dy, ahead;
        logic [63:0] len;
        clipped = 1'b0;
        f = '0;
        sx = 64'(i_self_x);
        sy = 64'(i_self_y);
        tx = 64'(i_target_x);
        ty = 64'(i_target_y);
        if (i_cmd == CMD_PURSUIT || i_cmd == CMD_EVADE) begin
            if (i_target_max_speed == 0) begin
                f.st = ST_ZTS;
                return f;
            end
            ahead = scale_clip($signed(vec_length(tx - sx, ty - sy)), ONE_Q,
                               64'(i_target_max_speed));
            tx = clip_word(tx + scale_clip(64'(i_target_vel_x), ahead, ONE_Q));
            ty = clip_word(ty + scale_clip(64'(i_target_vel_y), ahead, ONE_Q));
        end
        if (i_cmd == CMD_SEEK || i_cmd == CMD_PURSUIT) begin
            dx = tx - sx;
            dy = ty - sy;
        end else begin
            dx = sx - tx;
            dy = sy - ty;
        end
        len = vec_length(dx, dy);
        if (len <= 64'(dead_zone)) begin
            f.st = ST_DEAD;
            return f;
        end
        dx = scale_clip(dx, 64'(i_speed), len);
        dy = scale_clip(dy, 64'(i_speed), len);
        f.fx = t_word'(scale_clip(dx - 64'(i_self_vel_x), 64'(i_mass), ONE_Q));
        f.fy = t_word'(scale_clip(dy - 64'(i_self_vel_y), 64'(i_mass), ONE_Q));
        f.st = clipped ? ST_SAT : ST_OK;
        return f;
    endfunction

    initial begin
        mismatches = 0;
        dead_zone  = DZ_RESET;
    end

    always @(posedge i_clk) begin
        t_force want;
        if (!i_rst_n) begin
            dead_zone <= DZ_RESET;
            force_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) dead_zone <= i_cfg_data;
            if (start && !busy) force_q.push_back(predict_force());
            if (o_done) begin
                if (force_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: fx=%0d fy=%0d st=%0d",
                                 o_force_x, o_force_y, o_status);
                end else begin
                    want = force_q.pop_front();
                    if (want.fx !== o_force_x || want.fy !== o_force_y ||
                        want.st !== o_status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("force mismatch: exp fx=%0d fy=%0d st=%0d, got fx=%0d fy=%0d st=%0d",
                                     want.fx, want.fy, want.st,
                                     o_force_x, o_force_y, o_status);
                    end
                end
            end
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives steering requests and dead zone writes, gives the verdict
module testbench;
    import sfpe_pkg::*;

    localparam int STALL_LIMIT = 4 * PIPE_LAT + 200;
    localparam int PHASE_ITEMS = 110;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [CMD_W-1:0] i_cmd = CMD_SEEK;
    t_word           i_self_x = '0, i_self_y = '0, i_self_vel_x = '0, i_self_vel_y = '0;
    t_uns            i_speed = '0, i_mass = '0, i_target_max_speed = '0;
    t_word           i_target_x = '0, i_target_y = '0;
    t_word           i_target_vel_x = '0, i_target_vel_y = '0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    t_uns            i_cfg_data = '0;
    logic            o_done;
    t_word           o_force_x, o_force_y;
    logic [ST_W-1:0] o_status;
    int              fail_count, pending;
    int              quiet_cycles = 0;
    bit              allow_gaps;

    seek_flee_pursuit_evade_steering_top u_top (.*);

    steering_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic maybe_gap();
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input t_word sx, input t_word sy,
                                input t_word svx, input t_word svy,
                                input t_uns spd, input t_uns mass_v,
                                input t_word tx, input t_word ty,
                                input t_word tvx, input t_word tvy,
                                input t_uns tms);
        bit took;
        maybe_gap();
        start <= 1'b1;
        i_cmd <= cmd;
        i_self_x <= sx;
        i_self_y <= sy;
        i_self_vel_x <= svx;
        i_self_vel_y <= svy;
        i_speed <= spd;
        i_mass <= mass_v;
        i_target_x <= tx;
        i_target_y <= ty;
        i_target_vel_x <= tvx;
        i_target_vel_y <= tvy;
        i_target_max_speed <= tms;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // wait out the pipeline, then write the radius
    task automatic write_dead_zone(input t_uns radius);
        bit took;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= radius;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_word rand_coord(input int shape);
        case (shape)
            0:       return t_word'($urandom);
            1:       return t_word'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            default: return t_word'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        endcase
    endfunction

    function automatic t_uns rand_pos(input int shape);
        case (shape)
            0:       return t_uns'($urandom);
            1:       return t_uns'($urandom_range(0, 32'h00FF_FFFF));
            default: return t_uns'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    task automatic random_requests(input int count);
        int shape;
        logic [CMD_W-1:0] cmd;
        t_word sx, sy;
        for (int n = 0; n < count; n++) begin
            // mostly moderate, in-range agents; some full-range noise
            shape = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
            cmd = CMD_W'($urandom_range(0, 3));
            sx = rand_coord(shape);
            sy = rand_coord(shape);
            if ($urandom_range(0, 15) == 0) begin
                send_request(cmd, sx, sy, rand_coord(shape), rand_coord(shape),
                             rand_pos(shape), rand_pos(shape),
                             sx + t_word'($urandom_range(0, 8000)) - 4000, sy,
                             rand_coord(shape), rand_coord(shape),
                             ($urandom_range(0, 3) == 0) ? '0 : rand_pos(shape));
            end else begin
                send_request(cmd, sx, sy, rand_coord(shape), rand_coord(shape),
                             rand_pos(shape), rand_pos(shape),
                             rand_coord(shape), rand_coord(shape),
                             rand_coord(shape), rand_coord(shape),
                             ($urandom_range(0, 19) == 0) ? '0 : rand_pos(shape));
            end
        end
    endtask

    localparam t_word W_HI  = 32'sh7FFF_FFFF;
    localparam t_word W_LO  = 32'sh8000_0000;
    localparam t_uns  U_HI  = 31'h7FFF_FFFF;
    localparam t_word ONE   = 32'sh0001_0000;
    localparam t_uns  U_ONE = 31'h0001_0000;
    localparam t_uns  U_TWO = 31'h0002_0000;
    localparam t_uns  U_THR = 31'h0003_0000;

    initial begin
        allow_gaps = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain cases, one per command
        send_request(CMD_SEEK, 0, 0, ONE, -ONE, U_TWO, U_ONE, 10 * ONE, 5 * ONE, 0, 0, 0);
        send_request(CMD_FLEE, ONE, 2 * ONE, 0, ONE, U_ONE, U_THR, -4 * ONE, 7 * ONE,
                     W_HI, W_LO, U_HI);
        send_request(CMD_PURSUIT, 0, 0, 0, 0, U_THR, U_ONE, 20 * ONE, 0, 0, ONE, U_ONE);
        send_request(CMD_EVADE, 5 * ONE, 5 * ONE, ONE, ONE, U_ONE, U_TWO, 0, 0,
                     -ONE, ONE, U_TWO);
        // zero target speed in pursuit and evade, ignored in seek
        send_request(CMD_PURSUIT, 0, 0, ONE, ONE, U_ONE, U_ONE, ONE, ONE, ONE, ONE, 0);
        send_request(CMD_EVADE, W_HI, W_LO, W_HI, W_LO, U_HI, U_HI, W_LO, W_HI,
                     W_HI, W_LO, 0);
        send_request(CMD_SEEK, 0, 0, 0, 0, U_ONE, U_ONE, 8 * ONE, 0, W_LO, W_HI, 0);
        // inside, on and just beyond the dead zone edge
        send_request(CMD_SEEK, ONE, ONE, ONE, ONE, U_ONE, U_ONE, ONE, ONE, 0, 0, 0);
        send_request(CMD_FLEE, 0, 0, 0, 0, U_ONE, U_ONE, 6554, 0, 0, 0, 0);
        send_request(CMD_SEEK, 0, 0, 0, 0, U_ONE, U_ONE, 6555, 0, 0, 0, 0);
        // field extremes and saturation
        send_request(CMD_SEEK, W_LO, W_LO, W_HI, W_HI, U_HI, U_HI, W_HI, W_HI, 0, 0, 0);
        send_request(CMD_FLEE, W_HI, W_LO, W_LO, W_HI, U_HI, U_HI, W_LO, W_HI, 0, 0, 0);
        send_request(CMD_PURSUIT, W_LO, W_LO, 0, 0, U_HI, U_HI, W_HI, W_HI,
                     W_HI, W_HI, 1);
        send_request(CMD_EVADE, W_HI, W_HI, W_LO, W_LO, 0, 0, W_LO, W_LO,
                     W_LO, W_LO, U_HI);
        send_request(CMD_SEEK, -1, -1, -1, -1, 1, 1, 1, 1, -1, -1, 1);
        send_request(CMD_PURSUIT, 0, 0, 0, 0, 0, U_HI, ONE, ONE, ONE, -ONE, U_HI);

        random_requests(PHASE_ITEMS);
        write_dead_zone('0);
        send_request(CMD_SEEK, 0, 0, ONE, 0, U_ONE, U_ONE, 0, 0, 0, 0, 0);
        send_request(CMD_SEEK, 0, 0, ONE, 0, U_ONE, U_ONE, 1, 0, 0, 0, 0);
        random_requests(PHASE_ITEMS);
        write_dead_zone(U_HI);
        random_requests(40);
        write_dead_zone(t_uns'($urandom_range(1, 32'h0010_0000)));
        random_requests(PHASE_ITEMS);
        write_dead_zone(t_uns'($urandom));
        random_requests(PHASE_ITEMS);
        write_dead_zone(DZ_RESET);
        allow_gaps = 1'b0;
        random_requests(60);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/sfpe_pkg.sv
src/sfpe_norm.sv
src/sfpe_div.sv
src/seek_flee_pursuit_evade_steering_top.sv
sim/steering_checker.sv
sim/testbench.sv
